[rtl/core/xcpc_pkg.sv]
// ----------------------------------------------------------------------------
// xcpc_pkg: shared types and constants of the chained pixel cipher
// Holds the keystream shift amounts, the field widths, the register indexes,
// the sequencer state type and the control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xcpc_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int KS_WIDTH    = 32;
    localparam int PIX_WIDTH   = 24;
    localparam int CFG_WIDTH   = 32;
    localparam int CFG_IDX_W   = 2;

    localparam int SHL_A = 13;
    localparam int SHR_B = 17;
    localparam int SHL_C = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic ks_load_seed;
        logic ks_step;
        logic out_load;
    } t_ctrl;

endpackage

`default_nettype wire

[rtl/core/xcpc_keygen.sv]
// ----------------------------------------------------------------------------
// xcpc_keygen: xorshift32 keystream generator
// Holds the current keystream word; reload it from the seed, or advance it by
// one xorshift step per cycle while ks_step is set, else hold it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xcpc_keygen (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire xcpc_pkg::t_ctrl                i_ctrl,
    input  wire logic [xcpc_pkg::KS_WIDTH-1:0]  i_seed,
    output logic      [xcpc_pkg::KS_WIDTH-1:0]  o_word
);
    import xcpc_pkg::*;

    logic [KS_WIDTH-1:0] r_word;
    logic [KS_WIDTH-1:0] n_word;
    logic [KS_WIDTH-1:0] s1;
    logic [KS_WIDTH-1:0] s2;
    logic [KS_WIDTH-1:0] s3;

    // one xorshift step
    always_comb begin
        s1 = r_word ^ (r_word << SHL_A);
        s2 = s1 ^ (s1 >> SHR_B);
        s3 = s2 ^ (s2 << SHL_C);
    end

    always_comb begin
        priority if (i_ctrl.ks_load_seed) begin
            n_word = i_seed;
        end else if (i_ctrl.ks_step) begin
            n_word = s3;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

[rtl/core/xcpc_seq.sv]
// ----------------------------------------------------------------------------
// xcpc_seq: pixel sequencer
// Count the keystream steps one pixel needs and hand the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xcpc_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic                              i_first,
    input  wire logic [xcpc_pkg::COUNT_WIDTH-1:0]  i_pixel_count,
    input  wire logic                              i_out_free,
    output logic                                   o_ready,
    output xcpc_pkg::t_ctrl                        o_ctrl
);
    import xcpc_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    // next state and step count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_count = i_first ? i_pixel_count : COUNT_WIDTH'(1);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_count != '0) begin
                    n_count = r_count - COUNT_WIDTH'(1);
                end
                if (r_count == '0 || r_count == COUNT_WIDTH'(1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready             = 1'b1;
                o_ctrl.ks_load_seed = i_start & i_first;
            end
            ST_RUN: begin
                o_ctrl.ks_step = (r_count != '0);
            end
            ST_WRITE: begin
                o_ctrl.out_load = i_out_free;
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[rtl/core/xorshift_chained_pixel_cipher.sv]
// ----------------------------------------------------------------------------
// xorshift_chained_pixel_cipher: chained-XOR RGB pixel cipher, xorshift32 key
//
// Slave stream: one beat is one pixel; tdata carries blue, green, red from
// the low byte up, tuser marks the first pixel of a frame. Master stream:
// one beat per accepted pixel, same byte order in tdata.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high (key seed, start value, pixel count, decrypt mode); write only while
// no pixel is in flight.
// Timing: one pixel is worked at a time by a single xorshift step unit that
// advances the keystream one word per cycle while the sequencer steps it. A
// chained pixel takes one keystream step; a first pixel of a frame reloads the
// seed and steps pixel_count times (no step when pixel_count is zero). The
// result is loaded into the output register from the sequencer's write state,
// drives m_axis_tvalid from there, and the slave side is then ready again.
// Stall: the result beat holds in the output register while m_axis_tready is
// low; a finished pixel waits in the sequencer and the slave side stays not
// ready until the output register frees up.
// Reset: clears the keystream word and chain pixel, sets pixel_count to 1 and
// the other configuration registers to zero, and drops any pending beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xorshift_chained_pixel_cipher (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [xcpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [xcpc_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    // slave stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [xcpc_pkg::PIX_WIDTH-1:0]   s_axis_tdata,  // blue_in, green_in, red_in
    input  wire logic                             s_axis_tuser,  // frame_first
    // master stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [xcpc_pkg::PIX_WIDTH-1:0]   m_axis_tdata   // blue_out, green_out, red_out
);
    import xcpc_pkg::*;

    // configuration registers
    logic [KS_WIDTH-1:0]    r_key_seed;
    logic [PIX_WIDTH-1:0]   r_start_value;
    logic [COUNT_WIDTH-1:0] r_pixel_count;
    logic                   r_decrypt;

    // pixel in flight and chain state
    logic [PIX_WIDTH-1:0]   r_pix;
    logic                   r_first;
    logic [PIX_WIDTH-1:0]   r_chain;

    // output register
    logic [PIX_WIDTH-1:0]   r_out_data;
    logic                   r_out_valid;

    logic                   s_accept;
    logic                   out_free;
    logic [PIX_WIDTH-1:0]   n_result;
    logic [KS_WIDTH-1:0]    ks_word;
    t_ctrl                  ctrl;

    assign s_accept = s_axis_tvalid & s_axis_tready;
    assign out_free = ~r_out_valid | m_axis_tready;

    xcpc_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (s_accept),
        .i_first       (s_axis_tuser),
        .i_pixel_count (r_pixel_count),
        .i_out_free    (out_free),
        .o_ready       (s_axis_tready),
        .o_ctrl        (ctrl)
    );

    xcpc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_seed  (r_key_seed),
        .o_word  (ks_word)
    );

    // first pixel XORs the start value, later pixels the chain
    assign n_result = r_pix ^ (r_first ? r_start_value : r_chain) ^ ks_word[PIX_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed    <= '0;
            r_start_value <= '0;
            r_pixel_count <= COUNT_WIDTH'(1);
            r_decrypt     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_SEED:     r_key_seed    <= i_cfg_data[KS_WIDTH-1:0];
                REG_START_VALUE:  r_start_value <= i_cfg_data[PIX_WIDTH-1:0];
                REG_PIXEL_COUNT:  r_pixel_count <= i_cfg_data[COUNT_WIDTH-1:0];
                REG_DECRYPT_MODE: r_decrypt     <= i_cfg_data[0];
                default:          r_decrypt     <= r_decrypt;
            endcase
        end
    end

    // capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_pix   <= s_axis_tdata;
            r_first <= s_axis_tuser;
        end
    end

    // advance the chain when the result leaves for the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (ctrl.out_load) begin
            r_chain <= r_decrypt ? r_pix : n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_data <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/core/xcpc_checker.sv]
// ----------------------------------------------------------------------------
// xcpc_checker: port-level checks of the chained pixel cipher
// Watches the stream handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xcpc_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    input  wire logic s_axis_tready,
    input  wire logic m_axis_tvalid,
    input  wire logic m_axis_tready
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // one pixel at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a pixel is in flight");

    // a new result only comes while the input side is busy
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in flight");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind xorshift_chained_pixel_cipher xcpc_checker u_xcpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
